[hdl/spma_pkg.sv]
// Shared types and constants for the sparse polynomial merge-add unit.
// Holds the input and output word structs, the stored term layout,
// the mode codes and the sequencer state type. Depends on nothing.
package spma_pkg;

  localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [1:0] MODE_ADD         = 2'd2;
  localparam logic [1:0] MODE_CLEAR       = 2'd3;

  typedef struct packed {
    logic        [1:0]  mode;
    logic signed [15:0] coefficient;
    logic        [7:0]  exponent;
  } in_word_t;

  typedef struct packed {
    logic signed [16:0] sum_coefficient;
    logic        [7:0]  sum_exponent;
    logic               last;
    logic               empty_res;
    logic               overflow;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] coef;
    logic        [7:0]  exp;
  } term_t;

  localparam int TERM_W = $bits(term_t);

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } emit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MERGE,
    ST_EMPTY
  } state_t;

endpackage

[hdl/spma_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Width and depth are parameters. Depends on nothing.
module spma_ram #(
  parameter int  WIDTH = 24,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/spma_out.sv]
// Output register stage: holds one result word until it is taken.
// Uses spma_pkg for the word types.
module spma_out (
  input  logic               clk,
  input  logic               rst,
  input  spma_pkg::emit_t    emit,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output spma_pkg::out_word_t out_data
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && emit.valid) begin
      out_data <= emit.word;
    end
  end

endmodule

[hdl/spma_ctrl.sv]
// Sequencer for loads, clears and the merge walk over both term memories.
// Uses spma_pkg; drives the ports of two spma_ram instances.
module spma_ctrl #(
  parameter int  MAX_TERMS = 32,
  localparam int CW = $clog2(MAX_TERMS + 1),
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  spma_pkg::in_word_t         in_data,
  output logic                       a_wr_en,
  output logic                       b_wr_en,
  output logic [AW-1:0]              a_wr_addr,
  output logic [AW-1:0]              b_wr_addr,
  output logic [spma_pkg::TERM_W-1:0] wr_data,
  output logic [AW-1:0]              a_rd_addr,
  output logic [AW-1:0]              b_rd_addr,
  input  logic [spma_pkg::TERM_W-1:0] a_rd_data,
  input  logic [spma_pkg::TERM_W-1:0] b_rd_data,
  input  logic                       out_free,
  output spma_pkg::emit_t            emit
);

  spma_pkg::state_t state, state_next;
  logic [CW-1:0] first_count, second_count;
  logic [CW-1:0] i, j, i_next, j_next;
  logic          overflow_seen;

  spma_pkg::term_t a_term, b_term, new_term;
  logic            accept, have_a, have_b, take_a, take_b, run_last;
  logic            first_full, second_full;
  logic signed [16:0] sum_coef;
  logic        [7:0]  sum_exp;

  assign accept      = in_valid && in_ready;
  assign first_full  = (first_count == CW'(MAX_TERMS));
  assign second_full = (second_count == CW'(MAX_TERMS));

  assign new_term.coef = in_data.coefficient;
  assign new_term.exp  = in_data.exponent;
  assign wr_data       = new_term;
  assign a_wr_addr     = first_count[AW-1:0];
  assign b_wr_addr     = second_count[AW-1:0];
  assign a_wr_en = accept && (in_data.mode == spma_pkg::MODE_LOAD_FIRST) && !first_full;
  assign b_wr_en = accept && (in_data.mode == spma_pkg::MODE_LOAD_SECOND) && !second_full;
  assign a_rd_addr = i[AW-1:0];
  assign b_rd_addr = j[AW-1:0];

  always_comb begin
    a_term   = a_rd_data;
    b_term   = b_rd_data;
    have_a   = (i < first_count);
    have_b   = (j < second_count);
    take_a   = have_a && (!have_b || (a_term.exp >= b_term.exp));
    take_b   = have_b && (!have_a || (b_term.exp >= a_term.exp));
    sum_coef = (take_a ? 17'(a_term.coef) : 17'sd0) + (take_b ? 17'(b_term.coef) : 17'sd0);
    sum_exp  = take_a ? a_term.exp : b_term.exp;
    i_next   = i + CW'(take_a);
    j_next   = j + CW'(take_b);
    run_last = (i_next >= first_count) && (j_next >= second_count);
  end

  always_comb begin
    state_next = state;
    case (state)
      spma_pkg::ST_IDLE: begin
        if (accept && (in_data.mode == spma_pkg::MODE_ADD)) begin
          if ((first_count == '0) && (second_count == '0)) begin
            state_next = spma_pkg::ST_EMPTY;
          end else begin
            state_next = spma_pkg::ST_READ;
          end
        end
      end
      spma_pkg::ST_READ: begin
        state_next = spma_pkg::ST_MERGE;
      end
      spma_pkg::ST_MERGE: begin
        if (out_free) begin
          state_next = run_last ? spma_pkg::ST_IDLE : spma_pkg::ST_READ;
        end
      end
      spma_pkg::ST_EMPTY: begin
        if (out_free) begin
          state_next = spma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spma_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready                  = 1'b0;
    emit.valid                = 1'b0;
    emit.word.sum_coefficient = sum_coef;
    emit.word.sum_exponent    = sum_exp;
    emit.word.last            = run_last;
    emit.word.empty_res       = 1'b0;
    emit.word.overflow        = overflow_seen;
    case (state)
      spma_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      spma_pkg::ST_MERGE: begin
        emit.valid = out_free;
      end
      spma_pkg::ST_EMPTY: begin
        emit.valid                = out_free;
        emit.word.sum_coefficient = '0;
        emit.word.sum_exponent    = '0;
        emit.word.last            = 1'b1;
        emit.word.empty_res       = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= spma_pkg::ST_IDLE;
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
      i             <= '0;
      j             <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (in_data.mode)
          spma_pkg::MODE_LOAD_FIRST: begin
            if (first_full) begin
              overflow_seen <= 1'b1;
            end else begin
              first_count <= first_count + CW'(1);
            end
          end
          spma_pkg::MODE_LOAD_SECOND: begin
            if (second_full) begin
              overflow_seen <= 1'b1;
            end else begin
              second_count <= second_count + CW'(1);
            end
          end
          spma_pkg::MODE_ADD: begin
            i <= '0;
            j <= '0;
          end
          spma_pkg::MODE_CLEAR: begin
            first_count  <= '0;
            second_count <= '0;
          end
          default: begin
            i <= '0;
          end
        endcase
      end else if ((state == spma_pkg::ST_MERGE) && out_free) begin
        i <= i_next;
        j <= j_next;
      end
    end
  end

endmodule

[hdl/sparse_polynomial_merge_add_unit.sv]
// Top level of the sparse polynomial merge-add unit.
// Depends on spma_pkg, spma_ram, spma_ctrl and spma_out.
//
//   channel   direction   handshake              word
//   in        input       in_valid / in_ready    spma_pkg::in_word_t
//   out       output      out_valid / out_ready  spma_pkg::out_word_t
//
// Loads and clears are taken while idle. An add is accepted and then gives each result
// term in order: read the head of each list from its memory, then compare, add and
// register the term. Two empty lists give a single empty word.
// Reset clears the counts and the overflow flag at once; the term memories are not cleared.
// A merge holds its place while the output register is full, and input waits until the
// run has ended.
module sparse_polynomial_merge_add_unit #(
  parameter int MAX_TERMS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  spma_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output spma_pkg::out_word_t out_data
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  logic                        a_wr_en, b_wr_en, out_free;
  logic [AW-1:0]               a_wr_addr, b_wr_addr, a_rd_addr, b_rd_addr;
  logic [spma_pkg::TERM_W-1:0] wr_data, a_rd_data, b_rd_data;
  spma_pkg::emit_t             emit;

  spma_ram #(.WIDTH(spma_pkg::TERM_W), .DEPTH(MAX_TERMS)) u_first_ram (
    .clk     (clk),
    .wr_en   (a_wr_en),
    .wr_addr (a_wr_addr),
    .wr_data (wr_data),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data)
  );

  spma_ram #(.WIDTH(spma_pkg::TERM_W), .DEPTH(MAX_TERMS)) u_second_ram (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (b_wr_addr),
    .wr_data (wr_data),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  spma_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .a_wr_en   (a_wr_en),
    .b_wr_en   (b_wr_en),
    .a_wr_addr (a_wr_addr),
    .b_wr_addr (b_wr_addr),
    .wr_data   (wr_data),
    .a_rd_addr (a_rd_addr),
    .b_rd_addr (b_rd_addr),
    .a_rd_data (a_rd_data),
    .b_rd_data (b_rd_data),
    .out_free  (out_free),
    .emit      (emit)
  );

  spma_out u_out (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.empty_res |-> out_data.last && (out_data.sum_coefficient == 17'sd0))
    else $error("empty result word is not a lone last word with zero coefficient");

  a_no_emit_when_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !emit.valid)
    else $error("result emitted while input is being accepted");

  a_emit_into_free_stage: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> out_free)
    else $error("result emitted into an occupied output stage");

endmodule
